FILE: rtl/mpcm_pkg.sv
// shared types, codes and constants of the command mailbox
package mpcm_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_AW  = 3;
    localparam int unsigned TDATA_W = 16;

    localparam logic [BYTE_W-1:0] NO_DATA       = 8'hFF;
    localparam logic [BYTE_W-1:0] VER_MAJOR_RST = 8'h04;
    localparam logic [BYTE_W-1:0] VER_MINOR_RST = 8'h31;
    localparam logic [BYTE_W-1:0] CMD_MAX       = 8'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_MAGIC_FIRST   = 3'd0,
        CFG_MAGIC_SECOND  = 3'd1,
        CFG_EMULATOR_ID   = 3'd2,
        CFG_HOST_ID       = 3'd3,
        CFG_VERSION_MAJOR = 3'd4,
        CFG_VERSION_MINOR = 3'd5
    } t_cfg_idx;

    // command codes
    typedef enum logic [1:0] {
        CMD_IDENTIFY = 2'd0,
        CMD_VERSION  = 2'd1,
        CMD_LIMIT    = 2'd2,
        CMD_UNLIMIT  = 2'd3
    } t_cmd;

    // protocol states
    typedef enum logic [2:0] {
        ST_MAGIC1 = 3'd0,
        ST_MAGIC2 = 3'd1,
        ST_CMD    = 3'd2,
        ST_ERR    = 3'd3,
        ST_DONE   = 3'd4,
        ST_RET1   = 3'd5,
        ST_RET2   = 3'd6
    } t_state;

    // configuration registers as seen by the protocol machine
    typedef struct packed {
        logic [BYTE_W-1:0] magic_first;
        logic [BYTE_W-1:0] magic_second;
        logic [BYTE_W-1:0] emulator_id;
        logic [BYTE_W-1:0] host_id;
        logic [BYTE_W-1:0] version_major;
        logic [BYTE_W-1:0] version_minor;
    } t_cfg;

    // number of return bytes each command yields
    function automatic logic [1:0] returns_of(input t_cmd cmd);
        logic [1:0] n;
        unique case (cmd)
            CMD_IDENTIFY: n = 2'd2;
            CMD_VERSION:  n = 2'd2;
            CMD_LIMIT:    n = 2'd0;
            CMD_UNLIMIT:  n = 2'd0;
            default:      n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/mpcm_cfg_regs.sv
// configuration register file of the command mailbox
module mpcm_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mpcm_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [mpcm_pkg::BYTE_W-1:0]   i_cfg_data,
    output mpcm_pkg::t_cfg                o_cfg
);
    import mpcm_pkg::*;

    t_cfg r_cfg;

    // register writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_first   <= '0;
            r_cfg.magic_second  <= '0;
            r_cfg.emulator_id   <= '0;
            r_cfg.host_id       <= '0;
            r_cfg.version_major <= VER_MAJOR_RST;
            r_cfg.version_minor <= VER_MINOR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MAGIC_FIRST:   r_cfg.magic_first   <= i_cfg_data;
                CFG_MAGIC_SECOND:  r_cfg.magic_second  <= i_cfg_data;
                CFG_EMULATOR_ID:   r_cfg.emulator_id   <= i_cfg_data;
                CFG_HOST_ID:       r_cfg.host_id       <= i_cfg_data;
                CFG_VERSION_MAJOR: r_cfg.version_major <= i_cfg_data;
                CFG_VERSION_MINOR: r_cfg.version_minor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/mpcm_fsm.sv
// protocol state machine: magic prefix, command decode, status and return readout
module mpcm_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_func,
    input  logic [mpcm_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_limited,
    input  mpcm_pkg::t_cfg                i_cfg,
    output logic [mpcm_pkg::BYTE_W-1:0]   o_read_data,
    output logic                          o_req
);
    import mpcm_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic              r_status, n_status;
    logic [BYTE_W-1:0] r_ret1, n_ret1;
    logic [BYTE_W-1:0] r_ret2, n_ret2;
    logic [1:0]        r_rets, n_rets;
    t_cmd              cmd_in;

    assign cmd_in = t_cmd'(i_byte[1:0]);

    // state registers, advance once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_MAGIC1;
            r_cmd    <= CMD_IDENTIFY;
            r_status <= STATUS_OK;
            r_ret1   <= '0;
            r_ret2   <= '0;
            r_rets   <= '0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_status <= n_status;
            r_ret1   <= n_ret1;
            r_ret2   <= n_ret2;
            r_rets   <= n_rets;
        end
    end

    // next state and result of the current beat
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_ret1      = r_ret1;
        n_ret2      = r_ret2;
        n_rets      = r_rets;
        o_read_data = '0;
        o_req       = 1'b0;
        if (i_func == FUNC_WRITE) begin
            unique case (r_state)
                ST_MAGIC2: begin
                    if (i_byte == i_cfg.magic_second) begin
                        n_state = ST_CMD;
                    end else if (i_byte != i_cfg.magic_first) begin
                        n_state = ST_MAGIC1;
                    end
                end
                ST_CMD: begin
                    if (i_byte <= CMD_MAX) begin
                        // every command runs on its command byte
                        n_cmd    = cmd_in;
                        n_rets   = returns_of(cmd_in);
                        n_status = STATUS_OK;
                        n_state  = ST_DONE;
                        unique case (cmd_in)
                            CMD_IDENTIFY: begin
                                n_ret1 = i_cfg.emulator_id;
                                n_ret2 = i_cfg.host_id;
                            end
                            CMD_VERSION: begin
                                n_ret1 = i_cfg.version_major;
                                n_ret2 = i_cfg.version_minor;
                            end
                            CMD_LIMIT:   o_req = ~i_limited;
                            CMD_UNLIMIT: o_req = i_limited;
                            default: ;
                        endcase
                    end else begin
                        n_status = STATUS_BAD;
                        n_state  = ST_ERR;
                    end
                end
                default: begin
                    // idle, error, done and return states restart the prefix
                    n_state = (i_byte == i_cfg.magic_first) ? ST_MAGIC2 : ST_MAGIC1;
                end
            endcase
        end else begin
            unique case (r_state)
                ST_ERR: begin
                    o_read_data = {{(BYTE_W-1){1'b0}}, r_status};
                    n_state     = ST_MAGIC1;
                end
                ST_DONE: begin
                    o_read_data = {{(BYTE_W-1){1'b0}}, r_status};
                    n_state     = (r_rets == 2'd0) ? ST_MAGIC1 : ST_RET1;
                end
                ST_RET1: begin
                    o_read_data = r_ret1;
                    n_state     = (r_rets == 2'd1) ? ST_MAGIC1 : ST_RET2;
                end
                ST_RET2: begin
                    o_read_data = r_ret2;
                    n_state     = ST_MAGIC1;
                end
                default: begin
                    // read during an incomplete sequence
                    o_read_data = NO_DATA;
                    n_state     = ST_MAGIC1;
                end
            endcase
        end
    end

endmodule

FILE: rtl/magic_prefixed_command_mailbox.sv
// top level of the byte-wide command mailbox with input and result registers
//
// channel  dir  handshake              payload
// s_axis   in   tvalid/tready          tuser: func; tdata: write_data, speed_limited
// m_axis   out  tvalid/tready          tdata: read_data, limit_change_request
// cfg      in   i_cfg_we (no wait)     i_cfg_addr index, i_cfg_data value
//
// one beat per cycle sustained while the output is not stalled; an accepted beat
// is held in the input register, decoded by the protocol machine and written
// into the result register when that register is free or draining, which
// raises m_axis_tvalid; the result then leaves when m_axis_tready is high.
// reset is synchronous, active low; it clears both registers' valid flags and
// the protocol state, and sets the configuration registers to their reset values.
// a stalled output holds its result; the input register keeps taking beats
// as long as its content can move into the result register.
module magic_prefixed_command_mailbox (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mpcm_pkg::TDATA_W-1:0]        s_axis_tdata,  // [7:0] write_data, [8] speed_limited
    input  logic                                s_axis_tuser,  // [0] func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mpcm_pkg::TDATA_W-1:0]        m_axis_tdata,  // [7:0] read_data, [8] limit_change_request
    input  logic                                i_cfg_we,
    input  logic [mpcm_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [mpcm_pkg::BYTE_W-1:0]         i_cfg_data
);
    import mpcm_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic              r_in_func;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_limited;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_req;
    logic              advance;
    logic [BYTE_W-1:0] fsm_read_data;
    logic              fsm_req;

    // move a beat into the result register when it is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    mpcm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mpcm_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_func      (r_in_func),
        .i_byte      (r_in_byte),
        .i_limited   (r_in_limited),
        .i_cfg       (cfg),
        .o_read_data (fsm_read_data),
        .o_req       (fsm_req)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func    <= s_axis_tuser;
            r_in_byte    <= s_axis_tdata[BYTE_W-1:0];
            r_in_limited <= s_axis_tdata[BYTE_W];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= fsm_read_data;
            r_out_req  <= fsm_req;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W-BYTE_W-1){1'b0}}, r_out_req, r_out_data};

endmodule

FILE: tb/tb.sv
// self-checking testbench for the command mailbox: directed script, then random protocol traffic
module tb;
    import mpcm_pkg::*;

    // one access on the input stream and the beat it returns
    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data;
        logic              limited;
    } t_mbox_access;

    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic              req;
    } t_mbox_result;

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } t_row_kind;

    // one line of the directed script
    typedef struct packed {
        t_row_kind         kind;
        t_cfg_idx          idx;
        logic [BYTE_W-1:0] val;
        t_mbox_access      acc;
        logic              typed;
        t_mbox_result      res;
    } t_script_row;

    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 187;
    localparam int HOLD_CYCLES = 60;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;  // [7:0] write_data, [8] speed_limited
    logic                  s_axis_tuser  = 1'b0; // [0] func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;         // [7:0] read_data, [8] limit_change_request
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr    = '0;
    logic [BYTE_W-1:0]     i_cfg_data    = '0;

    // predictor state, mirrors the mailbox protocol machine
    t_state            mb_state  = ST_MAGIC1;
    t_cmd              mb_cmd    = CMD_IDENTIFY;
    logic              mb_status = STATUS_OK;
    logic [BYTE_W-1:0] mb_ret1   = '0;
    logic [BYTE_W-1:0] mb_ret2   = '0;
    logic [1:0]        mb_nret   = '0;
    t_cfg              mb_cfg    = '{magic_first: '0, magic_second: '0, emulator_id: '0,
                                     host_id: '0, version_major: VER_MAJOR_RST,
                                     version_minor: VER_MINOR_RST};

    t_mbox_result pending_results[$];
    t_script_row  script[$];
    int           mismatch_count = 0;
    int           beats_sent     = 0;
    int           beats_checked  = 0;
    bit           hold_pending   = 1'b0;
    int           tx_run = 0, rx_run = 0;
    bit           tx_steady = 1'b0, rx_steady = 1'b0;

    magic_prefixed_command_mailbox dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // advance the mailbox by one access and return the beat it yields
    function automatic t_mbox_result mailbox_step(input t_mbox_access a);
        t_mbox_result r;
        r = '0;
        if (a.func == FUNC_WRITE) begin
            case (mb_state)
                ST_MAGIC2: begin
                    // second magic wins over a repeated first one
                    if (a.data == mb_cfg.magic_second) mb_state = ST_CMD;
                    else if (a.data != mb_cfg.magic_first) mb_state = ST_MAGIC1;
                end
                ST_CMD: begin
                    if (a.data <= CMD_MAX) begin
                        mb_cmd  = t_cmd'(a.data[1:0]);
                        mb_nret = (mb_cmd == CMD_IDENTIFY || mb_cmd == CMD_VERSION) ? 2'd2 : 2'd0;
                        case (mb_cmd)
                            CMD_IDENTIFY: begin
                                mb_ret1 = mb_cfg.emulator_id;
                                mb_ret2 = mb_cfg.host_id;
                            end
                            CMD_VERSION: begin
                                mb_ret1 = mb_cfg.version_major;
                                mb_ret2 = mb_cfg.version_minor;
                            end
                            CMD_LIMIT:   r.req = ~a.limited;
                            CMD_UNLIMIT: r.req = a.limited;
                            default: ;
                        endcase
                        mb_status = STATUS_OK;
                        mb_state  = ST_DONE;
                    end else begin
                        mb_status = STATUS_BAD;
                        mb_state  = ST_ERR;
                    end
                end
                // idle, finished or error: a write restarts the prefix
                default: mb_state = (a.data == mb_cfg.magic_first) ? ST_MAGIC2 : ST_MAGIC1;
            endcase
        end else begin
            case (mb_state)
                ST_ERR: begin
                    r.rd     = {7'd0, mb_status};
                    mb_state = ST_MAGIC1;
                end
                ST_DONE: begin
                    r.rd     = {7'd0, mb_status};
                    mb_state = (mb_nret == 2'd0) ? ST_MAGIC1 : ST_RET1;
                end
                ST_RET1: begin
                    r.rd     = mb_ret1;
                    mb_state = (mb_nret == 2'd1) ? ST_MAGIC1 : ST_RET2;
                end
                ST_RET2: begin
                    r.rd     = mb_ret2;
                    mb_state = ST_MAGIC1;
                end
                // sequence incomplete
                default: begin
                    r.rd     = NO_DATA;
                    mb_state = ST_MAGIC1;
                end
            endcase
        end
        return r;
    endfunction

    // idle cycles before the next beat, with runs of back-to-back traffic
    function automatic int draw_gap(inout int run_left, inout bit steady);
        if (run_left == 0) begin
            steady   = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(8, 40);
        end
        run_left--;
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic t_script_row beat(input logic f, input logic [BYTE_W-1:0] d,
                                         input logic l);
        t_script_row s;
        s       = '0;
        s.kind  = ROW_BEAT;
        s.acc   = '{func: f, data: d, limited: l};
        return s;
    endfunction

    function automatic t_script_row beat_is(input logic f, input logic [BYTE_W-1:0] d,
                                            input logic l, input logic [BYTE_W-1:0] rd,
                                            input logic rq);
        t_script_row s;
        s       = beat(f, d, l);
        s.typed = 1'b1;
        s.res   = '{rd: rd, req: rq};
        return s;
    endfunction

    function automatic t_script_row reg_row(input t_cfg_idx idx, input logic [BYTE_W-1:0] v);
        t_script_row s;
        s      = '0;
        s.kind = ROW_REG;
        s.idx  = idx;
        s.val  = v;
        return s;
    endfunction

    // drive one access and record what it must return once accepted
    task automatic send_access(input t_mbox_access a, input logic typed,
                               input t_mbox_result typed_res);
        int gap;
        t_mbox_result predicted;
        gap = draw_gap(tx_run, tx_steady);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= a.func;
        s_axis_tdata  <= {{(TDATA_W-9){1'b0}}, a.limited, a.data};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = mailbox_step(a);
        pending_results.push_back(typed ? typed_res : predicted);
        beats_sent++;
    endtask

    task automatic send_rand(input logic f, input logic [BYTE_W-1:0] d);
        send_access('{func: f, data: d, limited: 1'($urandom_range(0, 1))}, 1'b0, '0);
    endtask

    // stop offering beats and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [BYTE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_MAGIC_FIRST:   mb_cfg.magic_first   = v;
            CFG_MAGIC_SECOND:  mb_cfg.magic_second  = v;
            CFG_EMULATOR_ID:   mb_cfg.emulator_id   = v;
            CFG_HOST_ID:       mb_cfg.host_id       = v;
            CFG_VERSION_MAJOR: mb_cfg.version_major = v;
            CFG_VERSION_MINOR: mb_cfg.version_minor = v;
            default: ;
        endcase
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(CFG_MAGIC_FIRST,   c.magic_first);
        write_reg(CFG_MAGIC_SECOND,  c.magic_second);
        write_reg(CFG_EMULATOR_ID,   c.emulator_id);
        write_reg(CFG_HOST_ID,       c.host_id);
        write_reg(CFG_VERSION_MAJOR, c.version_major);
        write_reg(CFG_VERSION_MINOR, c.version_minor);
    endtask

    // one random exchange: mostly complete command sequences, some broken ones and noise
    task automatic random_exchange();
        int kind;
        int n;
        logic [BYTE_W-1:0] code;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            if ($urandom_range(0, 3) == 0) send_rand(FUNC_WRITE, mb_cfg.magic_first);
            send_rand(FUNC_WRITE, mb_cfg.magic_first);
            send_rand(FUNC_WRITE, mb_cfg.magic_second);
            code = ($urandom_range(0, 5) == 0) ? BYTE_W'($urandom_range(4, 255))
                                               : BYTE_W'($urandom_range(0, 3));
            send_rand(FUNC_WRITE, code);
            n = $urandom_range(0, 4);
            repeat (n) send_rand(FUNC_READ, BYTE_W'($urandom));
        end else if (kind == 7) begin
            // prefix cut short by a read or a stray write
            send_rand(FUNC_WRITE, mb_cfg.magic_first);
            if ($urandom_range(0, 1) == 1) send_rand(FUNC_WRITE, mb_cfg.magic_second);
            if ($urandom_range(0, 1) == 1) send_rand(FUNC_READ, BYTE_W'($urandom));
            else send_rand(FUNC_WRITE, BYTE_W'($urandom));
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_rand(1'($urandom_range(0, 1)), BYTE_W'($urandom));
        end
    endtask

    // result side: random back-pressure, one long hold-off on request, checks each beat
    initial begin : result_sink
        int gap;
        t_mbox_result want;
        t_mbox_result got;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_gap(rx_run, rx_steady);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.rd  = m_axis_tdata[BYTE_W-1:0];
            got.req = m_axis_tdata[BYTE_W];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: read_data %h request %b", got.rd, got.req);
            end else begin
                want = pending_results.pop_front();
                if (got.rd !== want.rd || got.req !== want.req) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat %0d: read_data exp %h got %h, request exp %b got %b",
                                 beats_checked, want.rd, got.rd, want.req, got.req);
                end
            end
            beats_checked++;
            @(negedge i_clk);
        end
    end

    // stimulus
    initial begin : stimulus
        t_cfg c;
        int target;
        logic [63:0] rnd;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: both magic bytes zero, version from reset
        script.push_back(beat_is(FUNC_READ, 8'h5C, 1'b1, NO_DATA, 1'b0));
        script.push_back(beat(FUNC_WRITE, 8'h00, 1'b1));
        script.push_back(beat(FUNC_WRITE, 8'h00, 1'b0));   // equal magic taken as second
        script.push_back(beat(FUNC_WRITE, 8'h01, 1'b1));
        script.push_back(beat_is(FUNC_READ, 8'hFF, 1'b0, {7'd0, STATUS_OK}, 1'b0));
        script.push_back(beat_is(FUNC_READ, 8'h00, 1'b0, VER_MAJOR_RST, 1'b0));
        script.push_back(beat_is(FUNC_READ, 8'h00, 1'b1, VER_MINOR_RST, 1'b0));
        script.push_back(beat_is(FUNC_READ, 8'h00, 1'b0, NO_DATA, 1'b0));
        // distinct magic bytes, extreme ids
        script.push_back(reg_row(CFG_MAGIC_FIRST,   8'hA5));
        script.push_back(reg_row(CFG_MAGIC_SECOND,  8'h5A));
        script.push_back(reg_row(CFG_EMULATOR_ID,   8'hFF));
        script.push_back(reg_row(CFG_HOST_ID,       8'h00));
        script.push_back(reg_row(CFG_VERSION_MAJOR, 8'hFF));
        script.push_back(reg_row(CFG_VERSION_MINOR, 8'h00));
        // repeated first magic, then an invalid command
        script.push_back(beat(FUNC_WRITE, 8'hA5, 1'b0));
        script.push_back(beat(FUNC_WRITE, 8'hA5, 1'b1));
        script.push_back(beat(FUNC_WRITE, 8'h5A, 1'b0));
        script.push_back(beat(FUNC_WRITE, 8'hFF, 1'b1));
        script.push_back(beat_is(FUNC_READ, 8'h00, 1'b0, {7'd0, STATUS_BAD}, 1'b0));
        script.push_back(beat_is(FUNC_READ, 8'h00, 1'b0, NO_DATA, 1'b0));
        // identify
        script.push_back(beat(FUNC_WRITE, 8'hA5, 1'b0));
        script.push_back(beat(FUNC_WRITE, 8'h5A, 1'b0));
        script.push_back(beat(FUNC_WRITE, 8'h00, 1'b0));
        script.push_back(beat(FUNC_READ,  8'h00, 1'b0));
        script.push_back(beat_is(FUNC_READ, 8'h00, 1'b0, 8'hFF, 1'b0));
        script.push_back(beat_is(FUNC_READ, 8'h00, 1'b0, 8'h00, 1'b0));
        // limit request, then a write after completion starting unlimit
        script.push_back(beat(FUNC_WRITE, 8'hA5, 1'b0));
        script.push_back(beat(FUNC_WRITE, 8'h5A, 1'b0));
        script.push_back(beat_is(FUNC_WRITE, 8'h02, 1'b0, 8'h00, 1'b1));
        script.push_back(beat(FUNC_WRITE, 8'hA5, 1'b1));
        script.push_back(beat(FUNC_WRITE, 8'h5A, 1'b1));
        script.push_back(beat_is(FUNC_WRITE, 8'h03, 1'b1, 8'h00, 1'b1));
        // read while the prefix is incomplete
        script.push_back(beat(FUNC_WRITE, 8'hA5, 1'b0));
        script.push_back(beat_is(FUNC_READ, 8'h00, 1'b0, NO_DATA, 1'b0));

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                drain();
                write_reg(script[i].idx, script[i].val);
            end else begin
                send_access(script[i].acc, script[i].typed, script[i].res);
            end
        end

        // random phases, each with its own register setting
        target = beats_sent;
        for (int p = 0; p < PHASES; p++) begin
            drain();
            rnd = {$urandom, $urandom};
            c = t_cfg'(rnd[$bits(t_cfg)-1:0]);
            if (p == 0) c = '0;
            else if (p == 1) c = '1;
            else if (p == 2) c.magic_second = c.magic_first;
            load_config(c);
            if (p == 0 || p == 3) hold_pending = 1'b1;
            target += PHASE_BEATS;
            while (beats_sent < target) random_exchange();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("magic_prefixed_command_mailbox verification clean");
        end else begin
            $display("magic_prefixed_command_mailbox verification failed");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #3000000;
        $display("magic_prefixed_command_mailbox verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/mpcm_pkg.sv
rtl/mpcm_cfg_regs.sv
rtl/mpcm_fsm.sv
rtl/magic_prefixed_command_mailbox.sv
tb/tb.sv
